### rtl/spml_pkg.sv
// Package for the SCPI program message lexer: state codes, event, type and
// error codes, result word type and defaults. No dependencies.
package spml_pkg;

   localparam int BufLenDefault = 64;
   localparam int MnemMax       = 11;

   typedef enum logic [28:0] {
      ST_P0   = 29'd1 << 0,  ST_P1   = 29'd1 << 1,  ST_P2   = 29'd1 << 2,
      ST_P5   = 29'd1 << 3,  ST_P6   = 29'd1 << 4,  ST_P7   = 29'd1 << 5,
      ST_P8   = 29'd1 << 6,  ST_C0   = 29'd1 << 7,  ST_D0   = 29'd1 << 8,
      ST_D1   = 29'd1 << 9,  ST_D2   = 29'd1 << 10, ST_D3   = 29'd1 << 11,
      ST_D4   = 29'd1 << 12, ST_D5   = 29'd1 << 13, ST_D6   = 29'd1 << 14,
      ST_D7   = 29'd1 << 15, ST_S0   = 29'd1 << 16, ST_S1   = 29'd1 << 17,
      ST_S2   = 29'd1 << 18, ST_S3   = 29'd1 << 19, ST_DA0  = 29'd1 << 20,
      ST_DA1  = 29'd1 << 21, ST_DA2  = 29'd1 << 22, ST_DA3  = 29'd1 << 23,
      ST_DA4  = 29'd1 << 24, ST_DA5  = 29'd1 << 25, ST_E0   = 29'd1 << 26,
      ST_LOAD = 29'd1 << 27, ST_ERR  = 29'd1 << 28
   } state_type;

   localparam logic [2:0] EV_IDLE = 3'd0, EV_UNIT = 3'd1, EV_SEMI = 3'd2,
                          EV_TERM = 3'd3, EV_ERR = 3'd4;

   localparam logic [3:0] PT_NONE = 4'd0, PT_CHAR = 4'd1, PT_DEC = 4'd2,
                          PT_STR = 4'd3, PT_HEX = 4'd4, PT_OCT = 4'd5,
                          PT_BIN = 4'd6, PT_DBLK = 4'd7, PT_IBLK = 4'd8;

   localparam logic [3:0] ER_NONE = 4'd0, ER_OVERRUN = 4'd1, ER_FRAMING = 4'd2,
                          ER_LINK = 4'd3, ER_CHAR = 4'd4, ER_MNEM = 4'd5,
                          ER_NUMCHR = 4'd6, ER_DIGITS = 4'd7, ER_BLOCK = 4'd8;

   localparam logic [1:0] NT_NONE = 2'd0, NT_BREAK = 2'd1, NT_LDIN = 2'd2,
                          NT_LDOUT = 2'd3;
   localparam logic [1:0] LA_KEEP = 2'd0, LA_START = 2'd1, LA_ROOT = 2'd2,
                          LA_COMMIT = 2'd3;

   localparam logic [1:0] LS_OK = 2'd0, LS_OVERRUN = 2'd1, LS_FRAMING = 2'd2;

   typedef struct packed {
      logic [2:0] event_res;
      logic [3:0] param_type;
      logic [3:0] error_code;
      logic       query_flag;
      logic       write_enable;
      logic [6:0] write_index;
      logic [7:0] write_char;
      logic       loader_valid;
      logic [7:0] loader_byte;
      logic [1:0] notice;
      logic [1:0] level_action;
   } rsp_type;

endpackage

### rtl/spml_if.sv
// Handshake channel interfaces for the lexer. Depends on spml_pkg.
interface spml_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [1:0] line_status;
   modport source (output valid, rx_byte, line_status, input ready);
   modport sink   (input valid, rx_byte, line_status, output ready);
endinterface

interface spml_rsp_if import spml_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/scpi_program_message_lexer.sv
// Top level of the SCPI program message lexer: one received word in, one
// result word out. Depends on spml_pkg and the channel interfaces.
//
// Throughput: one word per cycle while skid entry 1 is free; the single-pass
// state update is the only loop, and a two-entry skid buffer decouples the
// result side, which registers the result of each accepted word.
// Reset: synchronous, active high; returns to command start with all
// counters, types and errors cleared and the result buffer empty.
module scpi_program_message_lexer
   import spml_pkg::*;
#(
   parameter int BUF_LEN = BufLenDefault
) (
   input  logic    clock,
   input  logic    reset,
   spml_req_if.sink   req,
   spml_rsp_if.source rsp
);

   // ---------------- lexer state
   state_type   state_ff, state_in;
   logic [15:0] tidx_ff, tidx_in;
   logic [3:0]  ldig_ff, ldig_in;
   logic [15:0] blen_ff, blen_in;
   logic [3:0]  ptype_ff, ptype_in;
   logic [3:0]  err_ff, err_in;
   logic        query_ff, query_in;
   rsp_type     res;

   // ---------------- output skid: two entries
   rsp_type     q0_ff, q1_ff;
   logic        v0_ff, v1_ff;
   logic        accept, pop;

   assign req.ready = !v1_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = v0_ff && rsp.ready;
   assign rsp.valid = v0_ff;
   assign rsp.data  = q0_ff;

   // ---------------- character classes
   logic [7:0] b, u;
   logic is_ws, is_nl, is_alpha, is_digit, is_hex, is_name, is_sep;
   logic [2:0] sep_ev;
   state_type  sep_st;

   assign b        = req.rx_byte;
   assign u        = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
   assign is_nl    = u == 8'h0A;
   assign is_ws    = u <= 8'h20 && !is_nl;
   assign is_alpha = u >= 8'h41 && u <= 8'h5A;
   assign is_digit = u >= 8'h30 && u <= 8'h39;
   assign is_hex   = is_digit || (u >= 8'h41 && u <= 8'h46);
   assign is_name  = is_alpha || is_digit || u == 8'h5F;
   assign is_sep   = u == 8'h3B || u == 8'h2C || is_nl;
   assign sep_ev   = (u == 8'h3B) ? EV_SEMI : (u == 8'h2C) ? EV_UNIT : EV_TERM;
   assign sep_st   = (u == 8'h2C) ? ST_P8 : ST_P0;

   localparam logic [15:0] BufLen16 = 16'(BUF_LEN);

   logic [15:0] tinc;
   assign tinc = tidx_ff + 16'd1;

   always_comb begin
      logic [15:0] widx;
      logic        wreq;
      logic [7:0]  wch;
      logic        ev_set;
      logic [2:0]  ev;

      state_in = state_ff; tidx_in = tidx_ff; ldig_in = ldig_ff;
      blen_in = blen_ff; ptype_in = ptype_ff; err_in = err_ff;
      query_in = query_ff;
      widx = '0; wreq = 1'b0; wch = '0; ev_set = 1'b0; ev = EV_IDLE;
      res = '0;

      if (req.line_status == LS_OK && b == 8'h03 && state_ff != ST_DA4 &&
          state_ff != ST_DA5) begin
         res.notice = NT_BREAK; state_in = ST_P0; ev_set = 1'b1;
      end else if (req.line_status != LS_OK || b[7]) begin
         err_in   = (req.line_status == LS_OVERRUN) ? ER_OVERRUN :
                    (req.line_status == LS_FRAMING) ? ER_FRAMING : ER_LINK;
         state_in = ST_ERR;
      end else begin
         unique case (state_ff)
            ST_P0: begin
               ptype_in = PT_NONE; err_in = ER_NONE; query_in = 1'b0;
               if (is_ws || u == 8'h3B) begin
               end else if (is_alpha) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u;
                  state_in = ST_P2; res.level_action = LA_START;
               end else if (u == 8'h3A) begin
                  state_in = ST_P1; res.level_action = LA_ROOT;
               end else if (u == 8'h2A) begin
                  res.notice = NT_LDIN; state_in = ST_LOAD;
               end else if (is_nl) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0;
                  res.level_action = LA_ROOT; ev_set = 1'b1; ev = EV_TERM;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_P1: begin
               if (is_alpha) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u; state_in = ST_P2;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_P2, ST_P5: begin
               if (is_ws) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc;
                  state_in = ST_P6; ev_set = 1'b1; ev = EV_UNIT;
               end else if (state_ff == ST_P2 && is_name) begin
                  res.level_action = LA_COMMIT;
                  if (tidx_ff < 16'(MnemMax)) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                  end else begin
                     err_in = ER_MNEM; state_in = ST_ERR;
                  end
               end else if (state_ff == ST_P2 && u == 8'h3F) begin
                  state_in = ST_P5; query_in = 1'b1;
               end else if (is_sep && u != 8'h2C) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_P6, ST_P8: begin
               if (is_ws) begin
               end else if (is_alpha) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u; state_in = ST_C0;
               end else if (is_digit) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u; state_in = ST_D2;
               end else if (u == 8'h2B || u == 8'h2D) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u; state_in = ST_D0;
               end else if (u == 8'h2E) begin
                  tidx_in = '0; wreq = 1'b1; widx = '0; wch = u; state_in = ST_D1;
               end else if (u == 8'h23) begin
                  state_in = ST_DA0;
               end else if (u == 8'h22) begin
                  tidx_in = '0; state_in = ST_S2;
               end else if (u == 8'h27) begin
                  tidx_in = '0; state_in = ST_S0;
               end else if (u == 8'h28) begin
                  state_in = ST_E0;
               end else if (state_ff == ST_P6 && is_sep && u != 8'h2C) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_P7, ST_D4: begin
               if (is_ws) begin
               end else if (state_ff == ST_D4 && u == 8'h45) begin
                  if (tidx_ff < BufLen16) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                     state_in = ST_D5;
                  end else begin
                     err_in = ER_DIGITS; state_in = ST_ERR;
                  end
               end else if (is_sep) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_C0: begin
               if (is_ws) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc;
                  state_in = ST_P7; ptype_in = PT_CHAR;
               end else if (is_name) begin
                  if (tidx_ff < 16'(MnemMax)) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                  end else begin
                     err_in = ER_MNEM; state_in = ST_ERR;
                  end
               end else if (is_sep) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc; ptype_in = PT_CHAR;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_D0: begin
               if (is_digit || u == 8'h2E) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                  state_in = is_digit ? ST_D2 : ST_D1;
               end else begin
                  err_in = ER_NUMCHR; state_in = ST_ERR;
               end
            end
            ST_D1, ST_D6: begin
               if (is_digit) begin
                  if (tidx_ff < BufLen16) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                     state_in = (state_ff == ST_D1) ? ST_D3 : ST_D7;
                  end else begin
                     err_in = ER_DIGITS; state_in = ST_ERR;
                  end
               end else begin
                  err_in = (state_ff == ST_D1) ? ER_NUMCHR : ER_CHAR;
                  state_in = ST_ERR;
               end
            end
            ST_D2, ST_D3, ST_D7: begin
               if (is_ws) begin
                  state_in = (state_ff == ST_D7) ? ST_P7 : ST_D4;
                  ptype_in = PT_DEC;
               end else if (is_digit || (u == 8'h45 && state_ff != ST_D7)) begin
                  if (tidx_ff < BufLen16) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                     state_in = (u == 8'h45) ? ST_D5 : state_ff;
                  end else begin
                     err_in = ER_DIGITS; state_in = ST_ERR;
                  end
               end else if (state_ff == ST_D2 && u == 8'h2E) begin
                  tidx_in = tinc;
                  if (tinc < BufLen16) begin
                     wreq = 1'b1; widx = tinc; wch = u; state_in = ST_D3;
                  end else begin
                     err_in = ER_DIGITS; state_in = ST_ERR;
                  end
               end else if (is_sep) begin
                  tidx_in = tinc; wreq = 1'b1; widx = tinc; ptype_in = PT_DEC;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_D5: begin
               if (is_ws) begin
               end else if (is_digit || u == 8'h2B || u == 8'h2D) begin
                  if (tidx_ff < BufLen16) begin
                     tidx_in = tinc; wreq = 1'b1; widx = tinc; wch = u;
                     state_in = is_digit ? ST_D7 : ST_D6;
                  end else begin
                     err_in = ER_DIGITS; state_in = ST_ERR;
                  end
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_S0, ST_S2: begin
               if (u == ((state_ff == ST_S0) ? 8'h27 : 8'h22)) begin
                  state_in = (state_ff == ST_S0) ? ST_S1 : ST_S3;
               end else begin
                  wreq = 1'b1; widx = tidx_ff; wch = b; tidx_in = tinc;
               end
            end
            ST_S1, ST_S3, ST_DA1, ST_DA2, ST_DA3, ST_DA4: begin
               logic       keep;
               logic [3:0] pt;
               logic [3:0] bad;
               keep = 1'b0; pt = PT_STR; bad = ER_CHAR;
               case (state_ff)
                  ST_S1:  keep = u == 8'h27;
                  ST_S3:  keep = u == 8'h22;
                  ST_DA1: begin keep = is_hex; pt = PT_HEX; bad = ER_NUMCHR; end
                  ST_DA2: begin
                     keep = u >= 8'h30 && u <= 8'h37; pt = PT_OCT; bad = ER_NUMCHR;
                  end
                  ST_DA3: begin
                     keep = u == 8'h30 || u == 8'h31; pt = PT_BIN; bad = ER_NUMCHR;
                  end
                  default: begin
                     keep = tidx_ff < blen_ff; pt = PT_DBLK; bad = ER_BLOCK;
                  end
               endcase
               if (state_ff == ST_DA4 && ldig_ff != 4'd0) begin
                  if (is_digit) begin
                     ldig_in = ldig_ff - 4'd1;
                     blen_in = 16'((blen_ff << 3) + (blen_ff << 1) + {12'd0, u[3:0]});
                  end else begin
                     err_in = ER_BLOCK; state_in = ST_ERR;
                  end
               end else if (keep) begin
                  if (state_ff == ST_S1 || state_ff == ST_S3) begin
                     wreq = 1'b1; widx = tidx_ff; wch = u; tidx_in = tinc;
                     state_in = (state_ff == ST_S1) ? ST_S0 : ST_S2;
                  end else if (state_ff == ST_DA4) begin
                     wreq = 1'b1; widx = tidx_ff; wch = b; tidx_in = tinc;
                  end else if (tidx_ff < BufLen16) begin
                     wreq = 1'b1; widx = tidx_ff; wch = u; tidx_in = tinc;
                  end
               end else if (is_ws) begin
                  wreq = 1'b1; widx = tidx_ff; state_in = ST_P7; ptype_in = pt;
               end else if (is_sep) begin
                  wreq = 1'b1; widx = tidx_ff; ptype_in = pt;
                  state_in = sep_st; ev_set = 1'b1; ev = sep_ev;
               end else begin
                  err_in = bad; state_in = ST_ERR;
               end
            end
            ST_DA0: begin
               tidx_in = '0;
               if (u == 8'h42) state_in = ST_DA3;
               else if (u == 8'h51) state_in = ST_DA2;
               else if (u == 8'h48) state_in = ST_DA1;
               else if (u == 8'h30) state_in = ST_DA5;
               else if (is_digit) begin
                  ldig_in = u[3:0]; blen_in = '0; state_in = ST_DA4;
               end else begin
                  err_in = ER_CHAR; state_in = ST_ERR;
               end
            end
            ST_DA5: begin
               if (is_nl) begin
                  wreq = 1'b1; widx = tidx_ff; state_in = ST_P0;
                  ptype_in = PT_IBLK; ev_set = 1'b1; ev = EV_TERM;
               end else begin
                  wreq = 1'b1; widx = tidx_ff; wch = b; tidx_in = tinc;
               end
            end
            ST_E0: begin
               if (u == 8'h29) begin
                  state_in = ST_P7; ptype_in = PT_IBLK;
               end
            end
            ST_LOAD: begin
               if (b == 8'h2A) begin
                  res.notice = NT_LDOUT; state_in = ST_P0;
                  ev_set = 1'b1; ev = EV_SEMI;
               end else begin
                  res.loader_valid = 1'b1; res.loader_byte = b;
               end
            end
            ST_ERR: begin
               if (u == 8'h3B || is_nl) begin
                  state_in = ST_P0; ev_set = 1'b1;
                  ev = is_nl ? EV_TERM : EV_SEMI;
               end
            end
            default: state_in = ST_P0;
         endcase
      end

      // positions beyond the buffer are dropped
      if (wreq && widx <= BufLen16) begin
         res.write_enable = 1'b1;
         res.write_index  = widx[6:0];
         res.write_char   = wch;
      end
      res.event_res  = ev_set ? ev : ((state_in == ST_ERR) ? EV_ERR : EV_IDLE);
      res.param_type = ptype_in;
      res.error_code = err_in;
      res.query_flag = query_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_P0; tidx_ff <= '0; ldig_ff <= '0; blen_ff <= '0;
         ptype_ff <= PT_NONE; err_ff <= ER_NONE; query_ff <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in; tidx_ff <= tidx_in; ldig_ff <= ldig_in;
         blen_ff <= blen_in; ptype_ff <= ptype_in; err_ff <= err_in;
         query_ff <= query_in;
      end
   end

   // result queue: entry 0 drives the port, entry 1 holds overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0;
      end else begin
         unique case ({accept, pop})
            2'b10: begin
               if (!v0_ff) begin v0_ff <= 1'b1; q0_ff <= res; end
               else begin v1_ff <= 1'b1; q1_ff <= res; end
            end
            2'b01: begin
               v0_ff <= v1_ff; q0_ff <= q1_ff; v1_ff <= 1'b0;
            end
            2'b11: begin
               if (v1_ff) begin q0_ff <= q1_ff; q1_ff <= res; end
               else q0_ff <= res;
            end
            default: ;
         endcase
      end
   end

endmodule

### rtl/spml_checker.sv
// Port-level checks for the lexer, bound to the top level.
// Depends on spml_pkg.
module spml_checker
   import spml_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_we_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |-> rsp_data.write_index == 7'd0)
      else $error("write index without write");

   a_err_ev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == EV_ERR |-> rsp_data.error_code != ER_NONE)
      else $error("error event without code");

   a_accept_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no result");

endmodule

bind scpi_program_message_lexer spml_checker u_spml_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

### bench/spml_lexer_checker.sv
// Checker for the SCPI program message lexer: watches both channels, predicts
// each result word and compares it. Depends on spml_pkg and the channel interfaces.
module spml_lexer_checker
   import spml_pkg::*;
#(
   parameter int BUF_LEN = BufLenDefault
) (
   input  logic clock,
   input  logic reset,
   spml_req_if  req_mon,
   spml_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   // lexer state mirror
   state_type   lex_state;
   logic [15:0] tok_idx;
   logic [15:0] blk_len;
   logic [3:0]  len_digits;
   logic [3:0]  cur_type;
   logic [3:0]  cur_err;
   logic        query_seen;
   int          ev;
   rsp_type     res;
   rsp_type     expected_words[$];

   function automatic bit is_ws(logic [7:0] u);
      return u <= 8'h20 && u != 8'h0A;
   endfunction
   function automatic bit is_alpha(logic [7:0] u);
      return u >= "A" && u <= "Z";
   endfunction
   function automatic bit is_digit(logic [7:0] u);
      return u >= "0" && u <= "9";
   endfunction
   function automatic bit is_name(logic [7:0] u);
      return is_alpha(u) || is_digit(u) || u == "_";
   endfunction

   function automatic void buf_write(logic [15:0] idx, logic [7:0] ch);
      if (idx <= BUF_LEN) begin
         res.write_enable = 1'b1;
         res.write_index  = idx[6:0];
         res.write_char   = ch;
      end
   endfunction
   function automatic void write_next(logic [7:0] ch);
      tok_idx = tok_idx + 16'd1;
      buf_write(tok_idx, ch);
   endfunction
   function automatic void write_here(logic [7:0] ch);
      buf_write(tok_idx, ch);
      tok_idx = tok_idx + 16'd1;
   endfunction
   function automatic void go_error(logic [3:0] code);
      cur_err   = code;
      lex_state = ST_ERR;
   endfunction

   // unit separator; at: terminator at current position; pt < 0 keeps type
   function automatic bit end_unit(logic [7:0] u, bit at, int pt);
      state_type nxt;
      int e;
      if (u == ";") begin nxt = ST_P0; e = EV_SEMI; end
      else if (u == ",") begin nxt = ST_P8; e = EV_UNIT; end
      else if (u == 8'h0A) begin nxt = ST_P0; e = EV_TERM; end
      else return 1'b0;
      if (at) buf_write(tok_idx, 8'h00); else write_next(8'h00);
      lex_state = nxt;
      if (pt >= 0) cur_type = pt[3:0];
      ev = e;
      return 1'b1;
   endfunction

   function automatic bit start_param(logic [7:0] u);
      if (is_alpha(u)) begin tok_idx = 0; buf_write(0, u); lex_state = ST_C0; end
      else if (is_digit(u)) begin tok_idx = 0; buf_write(0, u); lex_state = ST_D2; end
      else if (u == "+" || u == "-") begin
         tok_idx = 0; buf_write(0, u); lex_state = ST_D0;
      end
      else if (u == ".") begin tok_idx = 0; buf_write(0, u); lex_state = ST_D1; end
      else if (u == "#") lex_state = ST_DA0;
      else if (u == "\"") begin tok_idx = 0; lex_state = ST_S2; end
      else if (u == "'") begin tok_idx = 0; lex_state = ST_S0; end
      else if (u == "(") lex_state = ST_E0;
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic void add_digit(logic [7:0] u, state_type nxt);
      if (tok_idx < BUF_LEN) begin write_next(u); lex_state = nxt; end
      else go_error(ER_DIGITS);
   endfunction

   function automatic void value_tail(logic [7:0] u, logic [3:0] pt, logic [3:0] bad);
      if (is_ws(u)) begin
         buf_write(tok_idx, 8'h00); lex_state = ST_P7; cur_type = pt;
      end else if (!end_unit(u, 1'b1, pt)) go_error(bad);
   endfunction

   function automatic void radix_digit(logic [7:0] u, bit ok, logic [3:0] pt);
      if (ok) begin
         if (tok_idx < BUF_LEN) write_here(u);
      end else value_tail(u, pt, ER_NUMCHR);
   endfunction

   function automatic rsp_type lex_byte(logic [7:0] b, logic [1:0] ls);
      logic [7:0] u;
      state_type  s;
      u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      s = lex_state;
      ev = -1;
      res = '0;
      if (ls == LS_OK && b == 8'h03 && s != ST_DA4 && s != ST_DA5) begin
         res.notice = NT_BREAK; lex_state = ST_P0; ev = EV_IDLE;
      end else if (ls != LS_OK || b >= 8'h80) begin
         go_error(ls == LS_OVERRUN ? ER_OVERRUN : (ls == LS_FRAMING ? ER_FRAMING : ER_LINK));
      end else begin
         case (s)
            ST_P0: begin
               cur_type = PT_NONE; cur_err = ER_NONE; query_seen = 0;
               if (is_ws(u) || u == ";") ;
               else if (is_alpha(u)) begin
                  tok_idx = 0; buf_write(0, u); lex_state = ST_P2;
                  res.level_action = LA_START;
               end
               else if (u == ":") begin lex_state = ST_P1; res.level_action = LA_ROOT; end
               else if (u == "*") begin res.notice = NT_LDIN; lex_state = ST_LOAD; end
               else if (u == 8'h0A) begin
                  tok_idx = 0; buf_write(0, 8'h00); res.level_action = LA_ROOT; ev = EV_TERM;
               end
               else go_error(ER_CHAR);
            end
            ST_P1: begin
               if (is_alpha(u)) begin tok_idx = 0; buf_write(0, u); lex_state = ST_P2; end
               else go_error(ER_CHAR);
            end
            ST_P2, ST_P5: begin
               if (is_ws(u)) begin write_next(8'h00); lex_state = ST_P6; ev = EV_UNIT; end
               else if (s == ST_P2 && is_name(u)) begin
                  res.level_action = LA_COMMIT;
                  if (tok_idx < MnemMax) write_next(u); else go_error(ER_MNEM);
               end
               else if (s == ST_P2 && u == "?") begin lex_state = ST_P5; query_seen = 1; end
               else if (u == "," || !end_unit(u, 1'b0, -1)) go_error(ER_CHAR);
            end
            ST_P6: begin
               if (!(is_ws(u) || start_param(u)))
                  if (u == "," || !end_unit(u, 1'b0, -1)) go_error(ER_CHAR);
            end
            ST_P7: begin
               if (!is_ws(u) && !end_unit(u, 1'b0, -1)) go_error(ER_CHAR);
            end
            ST_P8: begin
               if (!(is_ws(u) || start_param(u))) go_error(ER_CHAR);
            end
            ST_C0: begin
               if (is_ws(u)) begin write_next(8'h00); lex_state = ST_P7; cur_type = PT_CHAR; end
               else if (is_name(u)) begin
                  if (tok_idx < MnemMax) write_next(u); else go_error(ER_MNEM);
               end
               else if (!end_unit(u, 1'b0, PT_CHAR)) go_error(ER_CHAR);
            end
            ST_D0: begin
               if (is_digit(u)) begin write_next(u); lex_state = ST_D2; end
               else if (u == ".") begin write_next(u); lex_state = ST_D1; end
               else go_error(ER_NUMCHR);
            end
            ST_D1: begin
               if (is_digit(u)) add_digit(u, ST_D3); else go_error(ER_NUMCHR);
            end
            ST_D2, ST_D3: begin
               if (is_ws(u)) begin lex_state = ST_D4; cur_type = PT_DEC; end
               else if (is_digit(u)) add_digit(u, s);
               else if (s == ST_D2 && u == ".") begin
                  tok_idx = tok_idx + 16'd1;
                  if (tok_idx < BUF_LEN) begin buf_write(tok_idx, u); lex_state = ST_D3; end
                  else go_error(ER_DIGITS);
               end
               else if (u == "E") add_digit(u, ST_D5);
               else if (!end_unit(u, 1'b0, PT_DEC)) go_error(ER_CHAR);
            end
            ST_D4: begin
               if (is_ws(u)) ;
               else if (u == "E") add_digit(u, ST_D5);
               else if (!end_unit(u, 1'b0, -1)) go_error(ER_CHAR);
            end
            ST_D5: begin
               if (is_ws(u)) ;
               else if (is_digit(u)) add_digit(u, ST_D7);
               else if (u == "+" || u == "-") add_digit(u, ST_D6);
               else go_error(ER_CHAR);
            end
            ST_D6: begin
               if (is_digit(u)) add_digit(u, ST_D7); else go_error(ER_CHAR);
            end
            ST_D7: begin
               if (is_ws(u)) begin lex_state = ST_P7; cur_type = PT_DEC; end
               else if (is_digit(u)) add_digit(u, ST_D7);
               else if (!end_unit(u, 1'b0, PT_DEC)) go_error(ER_CHAR);
            end
            ST_S0: if (u == "'") lex_state = ST_S1; else write_here(b);
            ST_S2: if (u == "\"") lex_state = ST_S3; else write_here(b);
            // doubled quote stays in the string
            ST_S1: if (u == "'") begin write_here(u); lex_state = ST_S0; end
                   else value_tail(u, PT_STR, ER_CHAR);
            ST_S3: if (u == "\"") begin write_here(u); lex_state = ST_S2; end
                   else value_tail(u, PT_STR, ER_CHAR);
            ST_DA0: begin
               tok_idx = 0;
               if (u == "B") lex_state = ST_DA3;
               else if (u == "Q") lex_state = ST_DA2;
               else if (u == "H") lex_state = ST_DA1;
               else if (u == "0") lex_state = ST_DA5;
               else if (is_digit(u)) begin
                  len_digits = 4'(u - "0"); blk_len = 0; lex_state = ST_DA4;
               end
               else go_error(ER_CHAR);
            end
            ST_DA1: radix_digit(u, is_digit(u) || (u >= "A" && u <= "F"), PT_HEX);
            ST_DA2: radix_digit(u, u >= "0" && u <= "7", PT_OCT);
            ST_DA3: radix_digit(u, u == "0" || u == "1", PT_BIN);
            ST_DA4: begin
               if (len_digits != 0) begin
                  if (is_digit(u)) begin
                     len_digits = len_digits - 4'd1;
                     blk_len = blk_len * 16'd10 + 16'(u - "0");
                  end else go_error(ER_BLOCK);
               end
               else if (tok_idx < blk_len) write_here(b);
               else value_tail(u, PT_DBLK, ER_BLOCK);
            end
            ST_DA5: begin
               if (u == 8'h0A) begin
                  buf_write(tok_idx, 8'h00); lex_state = ST_P0; cur_type = PT_IBLK;
                  ev = EV_TERM;
               end else write_here(b);
            end
            ST_E0: if (u == ")") begin lex_state = ST_P7; cur_type = PT_IBLK; end
            ST_LOAD: begin
               if (b == "*") begin res.notice = NT_LDOUT; lex_state = ST_P0; ev = EV_SEMI; end
               else begin res.loader_valid = 1'b1; res.loader_byte = b; end
            end
            ST_ERR: begin
               if (u == ";") begin lex_state = ST_P0; ev = EV_SEMI; end
               else if (u == 8'h0A) begin lex_state = ST_P0; ev = EV_TERM; end
            end
            default: lex_state = ST_P0;
         endcase
      end
      if (ev < 0) ev = (lex_state == ST_ERR) ? EV_ERR : EV_IDLE;
      res.event_res  = ev[2:0];
      res.param_type = cur_type;
      res.error_code = cur_err;
      res.query_flag = query_seen;
      return res;
   endfunction

   task automatic report(string field, int got, int want);
      $display("%0t mismatch on %s: got %0h expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         lex_state = ST_P0; tok_idx = 0; blk_len = 0; len_digits = 0;
         cur_type = PT_NONE; cur_err = ER_NONE; query_seen = 0;
         expected_words.delete();
         fail_count = 0; checked = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (expected_words.size() == 0) report("unexpected word", 1, 0);
            else begin
               want = expected_words.pop_front();
               checked++;
               if (got.event_res != want.event_res)
                  report("event_res", got.event_res, want.event_res);
               if (got.param_type != want.param_type)
                  report("param_type", got.param_type, want.param_type);
               if (got.error_code != want.error_code)
                  report("error_code", got.error_code, want.error_code);
               if (got.query_flag != want.query_flag)
                  report("query_flag", got.query_flag, want.query_flag);
               if (got.write_enable != want.write_enable)
                  report("write_enable", got.write_enable, want.write_enable);
               if (got.write_index != want.write_index)
                  report("write_index", got.write_index, want.write_index);
               if (got.write_char != want.write_char)
                  report("write_char", got.write_char, want.write_char);
               if (got.loader_valid != want.loader_valid)
                  report("loader_valid", got.loader_valid, want.loader_valid);
               if (got.loader_byte != want.loader_byte)
                  report("loader_byte", got.loader_byte, want.loader_byte);
               if (got.notice != want.notice)
                  report("notice", got.notice, want.notice);
               if (got.level_action != want.level_action)
                  report("level_action", got.level_action, want.level_action);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(lex_byte(req_mon.rx_byte, req_mon.line_status));
      end
      pending = expected_words.size();
   end

endmodule

### bench/scpi_program_message_lexer_tb.sv
// Testbench top for the SCPI program message lexer: clock, reset, word
// stimulus and verdict. Depends on spml_pkg, the channel interfaces and the checker.
module scpi_program_message_lexer_tb;
   import spml_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, checked;
   int   words_sent = 0;
   int   messages = 0;
   bit   calm = 1'b0;       // no idling on either side
   bit   held_off = 1'b0;   // long receiver stall already started
   int   hold_left = 0;

   spml_req_if req ();
   spml_rsp_if rsp ();

   scpi_program_message_lexer u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   spml_lexer_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req), .rsp_mon(rsp),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one long receiver hold-off once traffic is going, counted in cycles here
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      else if (!held_off && words_sent >= 300) begin
         held_off  <= 1'b1;
         hold_left <= 200;
      end
   end

   // receiver side: random stalls; the hold-off fills the skid buffer
   // so the lexer must drop req.ready
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_left > 0) rsp.ready <= 1'b0;
      else rsp.ready <= calm || ($urandom_range(0, 99) >= 28);
   end

   // one word on the request channel; waits for the handshake
   task automatic send(input logic [7:0] b, input logic [1:0] ls = LS_OK);
      while (!calm && $urandom_range(0, 99) < 28) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.rx_byte     <= b;
      req.line_status <= ls;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send(s[i]);
   endtask

   function automatic logic [7:0] pick(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // character of a well-formed message; now and then a stray word breaks it
   task automatic emit(input logic [7:0] b);
      send(b);
      if ($urandom_range(0, 150) == 0)
         send($urandom_range(0, 255), $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : LS_OK);
   endtask

   task automatic emit_spaces();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) emit(pick(" \t\r"));
   endtask

   task automatic emit_digits(input int n);
      repeat (n) emit(pick("0123456789"));
   endtask

   // one parameter; returns 1 when it already ended the message
   task automatic emit_param(output bit ended);
      int k, n;
      logic [7:0] q;
      ended = 1'b0;
      k = $urandom_range(0, 9);
      case (k)
         0: begin   // character data, sometimes too long
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 15) : $urandom_range(1, 8);
            emit(pick("ABCXYZabcxyz"));
            repeat (n - 1) emit(pick("ABZaz09_"));
         end
         1, 2: begin   // decimal, optionally with fraction and exponent
            if ($urandom_range(0, 2) == 0) emit(pick("+-"));
            n = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(1, 5);
            emit_digits(n);
            if ($urandom_range(0, 1)) begin emit("."); emit_digits($urandom_range(0, 4)); end
            if ($urandom_range(0, 1)) begin
               emit_spaces();
               emit(pick("Ee"));
               if ($urandom_range(0, 1)) emit(pick("+-"));
               emit_digits($urandom_range(1, 3));
            end
         end
         3: begin   // quoted string with doubled quotes
            q = pick("'\"");
            emit(q);
            n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(0, 10);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0) begin emit(q); emit(q); end
               else emit(pick("abcXYZ 019,;:#*"));
            end
            emit(q);
         end
         4: begin   // #H / #Q / #B, sometimes past the buffer or with a bad digit
            emit("#");
            n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
               0: begin emit(pick("Hh")); repeat (n) emit(pick("0123456789ABCDEFabcdef")); end
               1: begin emit(pick("Qq")); repeat (n) emit(pick("01234567")); end
               default: begin emit(pick("Bb")); repeat (n) emit(pick("01")); end
            endcase
            if ($urandom_range(0, 7) == 0) emit(pick("9GZ"));
         end
         5, 6: begin   // definite block with any content below 0x80
            emit("#");
            n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(0, 20);
            k = (n >= 10) ? $urandom_range(2, 3) : $urandom_range(1, 3);
            emit(8'("0") + 8'(k));
            if (k == 3) emit("0");
            if (k >= 2) emit(8'("0") + 8'(n / 10));
            emit(8'("0") + 8'(n % 10));
            repeat (n) emit($urandom_range(0, 127));
         end
         7: begin   // indefinite block runs to the newline
            emit("#"); emit("0");
            repeat ($urandom_range(0, 12)) emit(pick("ab;,#*\x03(Z"));
            emit(8'h0A);
            ended = 1'b1;
         end
         default: begin   // expression
            emit("(");
            repeat ($urandom_range(0, 6)) emit(pick("1+2*x ,;"));
            emit(")");
         end
      endcase
   endtask

   task automatic random_message();
      int r, n;
      bit ended;
      r = $urandom_range(0, 99);
      messages++;
      if (r < 6) begin   // noise, line errors and high bytes
         repeat ($urandom_range(1, 6))
            send($urandom_range(0, 255), $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : LS_OK);
         send(pick(";\n"));
      end else if (r < 9) begin   // break in the middle of a command
         send_str("VOLT ");
         emit_digits($urandom_range(0, 3));
         send(8'h03);
      end else if (r < 13) begin   // hex loader pass-through
         send("*");
         repeat ($urandom_range(0, 8)) send($urandom_range(0, 41));
         send("*");
      end else begin
         emit_spaces();
         if ($urandom_range(0, 3) == 0) emit(":");
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 14) : $urandom_range(1, 6);
         emit(pick("ABCMSVWZabmsz"));
         repeat (n - 1) emit(pick("AEQRTUaeqrtu019_"));
         if ($urandom_range(0, 2) == 0) emit("?");
         ended = 1'b0;
         if ($urandom_range(0, 3) != 0) begin
            emit(" ");
            emit_spaces();
            n = $urandom_range(1, 3);
            for (int i = 0; i < n && !ended; i++) begin
               if (i > 0) begin emit(","); emit_spaces(); end
               emit_param(ended);
               if (!ended) emit_spaces();
            end
         end
         if (!ended) emit(pick(";;\n"));
      end
   endtask

   initial begin
      req.valid       <= 1'b0;
      req.rx_byte     <= 8'h00;
      req.line_status <= LS_OK;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, line errors, break, loader, terminators
      send(8'h00); send(8'hFF); send(8'h0A);
      send("A", LS_OVERRUN); send("A", LS_FRAMING); send(8'h7F, 2'd3); send(8'h0A);
      send_str("m? 'a''b',#h1f;");
      send(8'h03);
      send_str("*\x01*");

      // random part; a stretch in the middle runs with no idling at all
      while (words_sent < 1320) begin
         calm = (words_sent >= 600 && words_sent < 800);
         random_message();
      end
      calm = 1'b0;
      req.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d words in %0d messages, %0d result words checked",
               words_sent, messages, checked);
      $display("headers, numbers, strings, radix numbers, blocks, loader, breaks, line errors");
      if (fail_count == 0 && pending == 0) begin
         $display("** scpi_program_message_lexer: PASSED **");
      end else begin
         $display("** scpi_program_message_lexer: FAILED **");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("** scpi_program_message_lexer: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/spml_pkg.sv
rtl/spml_if.sv
rtl/scpi_program_message_lexer.sv
rtl/spml_checker.sv
bench/spml_lexer_checker.sv
bench/scpi_program_message_lexer_tb.sv
